[design/lcgcc_pkg.sv]
package lcgcc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int LANES      = 5;
    localparam int IN_BITS    = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((2 * VALUE_BITS + 1 + 7) / 8) * 8;
    localparam int REG_COUNT  = 4;
    localparam int IDX_BITS   = $clog2(REG_COUNT);

    typedef enum logic [IDX_BITS-1:0] {
        REG_FIRST  = 2'd0,
        REG_SECOND = 2'd1,
        REG_THIRD  = 2'd2,
        REG_FOURTH = 2'd3
    } reg_idx_t;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t                            modulus;
        logic                              small_mod;
        logic [LANES-1:0][PROD_BITS-1:0]   num;
        logic [LANES-1:0][VALUE_BITS-1:0]  rem;
    } red_t;

    typedef struct packed {
        logic   match;
        value_t increment;
        value_t predicted_next;
    } result_t;

endpackage

[design/lcgcc_mul_stage.sv]
module lcgcc_mul_stage
    import lcgcc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  value_t multiplier,
    input  value_t modulus,
    input  value_t x1,
    input  value_t x2,
    input  value_t x3,
    input  value_t x4,
    output logic   out_valid,
    input  logic   out_ready,
    output red_t   out_data
);

    logic valid_reg;
    red_t data_reg;
    red_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = '0;
        data_next.modulus   = modulus;
        data_next.small_mod = (modulus < VALUE_BITS'(2));
        data_next.num[0]    = PROD_BITS'(multiplier) * PROD_BITS'(x1);
        data_next.num[1]    = PROD_BITS'(multiplier) * PROD_BITS'(x2);
        data_next.num[2]    = PROD_BITS'(multiplier) * PROD_BITS'(x3);
        data_next.num[3]    = PROD_BITS'(multiplier) * PROD_BITS'(x4);
        data_next.num[4]    = PROD_BITS'(x2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/lcgcc_mod_cell.sv]
module lcgcc_mod_cell
    import lcgcc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  red_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output red_t out_data
);

    logic valid_reg;
    red_t data_reg;
    red_t data_next;
    logic [VALUE_BITS:0] trial [LANES];

    assign in_ready = !valid_reg || out_ready;

    // one restoring step per lane: shift in the next numerator bit
    always_comb begin
        data_next = in_data;
        for (int i = 0; i < LANES; i++) begin
            trial[i] = {in_data.rem[i], in_data.num[i][PROD_BITS-1]};
            if (trial[i] >= {1'b0, in_data.modulus}) begin
                trial[i] = trial[i] - {1'b0, in_data.modulus};
            end
            data_next.rem[i] = trial[i][VALUE_BITS-1:0];
            data_next.num[i] = {in_data.num[i][PROD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/lcgcc_check.sv]
module lcgcc_check
    import lcgcc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  red_t    in_data,
    input  value_t  x2,
    input  value_t  x3,
    input  value_t  x4,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef struct packed {
        value_t                           modulus;
        logic                             small_mod;
        value_t                           incr;
        value_t                           incr_mod;
        logic [REG_COUNT-1:0][VALUE_BITS-1:0] rem;
    } mid_t;

    logic    mid_valid_reg;
    mid_t    mid_reg;
    mid_t    mid_next;
    logic    mid_ready;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic [VALUE_BITS:0] sum [REG_COUNT];
    value_t  nxt [REG_COUNT];
    value_t  r1;
    value_t  x2m;

    assign mid_ready = !res_valid_reg || out_ready;
    assign in_ready  = !mid_valid_reg || mid_ready;

    // increment and increment mod m
    always_comb begin
        r1  = in_data.rem[0];
        x2m = in_data.rem[4];
        mid_next.modulus   = in_data.modulus;
        mid_next.small_mod = in_data.small_mod;
        for (int i = 0; i < REG_COUNT; i++) begin
            mid_next.rem[i] = in_data.rem[i];
        end
        if (x2 >= r1) begin
            mid_next.incr = x2 - r1;
        end else begin
            mid_next.incr = VALUE_BITS'(({1'b0, x2} + {1'b0, in_data.modulus}) - {1'b0, r1});
        end
        if (x2m >= r1) begin
            mid_next.incr_mod = x2m - r1;
        end else begin
            mid_next.incr_mod = VALUE_BITS'(({1'b0, x2m} + {1'b0, in_data.modulus}) - {1'b0, r1});
        end
    end

    // next values and transition check
    always_comb begin
        for (int i = 0; i < REG_COUNT; i++) begin
            sum[i] = {1'b0, mid_reg.rem[i]} + {1'b0, mid_reg.incr_mod};
            if (sum[i] >= {1'b0, mid_reg.modulus}) begin
                sum[i] = sum[i] - {1'b0, mid_reg.modulus};
            end
            nxt[i] = sum[i][VALUE_BITS-1:0];
        end
        res_next.match = !mid_reg.small_mod && (nxt[0] == x2) && (nxt[1] == x3)
                         && (nxt[2] == x4);
        res_next.increment      = mid_reg.small_mod ? '0 : mid_reg.incr;
        res_next.predicted_next = mid_reg.small_mod ? '0 : nxt[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mid_valid_reg <= in_valid;
            end
            if (mid_ready) begin
                res_valid_reg <= mid_valid_reg;
            end
        end
        if (in_valid && in_ready) begin
            mid_reg <= mid_next;
        end
        if (mid_valid_reg && mid_ready) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

[design/lcg_candidate_checker_top.sv]
// lcg candidate checker
// input channel s_axis_*: one beat per candidate, multiplier and modulus
// result channel m_axis_*: one beat per candidate, match, increment and
// predicted fifth value
// cfg_*: writes the four observed values x1..x4 by index 0..3; always ready
// a chain of 2*VALUE_BITS reduction cells computes the five remainders
// (a*x1..a*x4 and x2, mod m), one quotient bit per cell
// a beat passes the multiply register, the cells, then the check's mid and result registers
// throughput: one candidate per cycle while m_axis_tready is high; every stage holds one beat
// when the receiver stalls, beats pile up stage by stage, so input keeps
// flowing until the chain is full, then s_axis_tready drops
// reset clears all valid flags and sets the observed values to zero
// moduli below two give a zero result
module lcg_candidate_checker_top
    import lcgcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_BITS-1:0]    s_axis_tdata,   // multiplier, modulus
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_BITS-1:0]   m_axis_tdata,   // match, increment, predicted_next, zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [VALUE_BITS-1:0] cfg_data
);

    value_t  x1_reg, x2_reg, x3_reg, x4_reg;
    logic    chain_valid [PROD_BITS+1];
    logic    chain_ready [PROD_BITS+1];
    red_t    chain_data  [PROD_BITS+1];
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            x3_reg <= '0;
            x4_reg <= '0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_FIRST:  x1_reg <= cfg_data;
                REG_SECOND: x2_reg <= cfg_data;
                REG_THIRD:  x3_reg <= cfg_data;
                REG_FOURTH: x4_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lcgcc_mul_stage u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .multiplier (s_axis_tdata[VALUE_BITS-1:0]),
        .modulus    (s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .x1         (x1_reg),
        .x2         (x2_reg),
        .x3         (x3_reg),
        .x4         (x4_reg),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_data   (chain_data[0])
    );

    for (genvar g = 0; g < PROD_BITS; g++) begin : g_cell
        lcgcc_mod_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    lcgcc_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[PROD_BITS]),
        .in_ready  (chain_ready[PROD_BITS]),
        .in_data   (chain_data[PROD_BITS]),
        .x2        (x2_reg),
        .x3        (x3_reg),
        .x4        (x4_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = OUT_BITS'({res.predicted_next, res.increment, res.match});

endmodule

[verif/tb_top.sv]
module tb_top;
    import lcgcc_pkg::*;

    localparam int LATENCY = 2 * VALUE_BITS + 3;

    typedef struct packed {
        logic   match;
        value_t increment;
        value_t predicted_next;
    } lcg_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_BITS-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_BITS-1:0]   m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [VALUE_BITS-1:0] cfg_data;

    value_t      observed [REG_COUNT];
    lcg_result_t expected_results [$];
    int          mismatch_count;
    int          result_count;
    int          candidate_count;
    int          match_count;
    int          hold_off_cycles;
    bit          rx_random_stall;

    lcg_candidate_checker_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic logic [63:0] step_mod(logic [63:0] a, logic [63:0] x,
                                             logic [63:0] c, logic [63:0] m);
        logic [63:0] p;
        p = (a * x) % m;
        return (p + (c % m)) % m;
    endfunction

    function automatic lcg_result_t check_candidate(value_t a, value_t m);
        lcg_result_t res;
        logic [63:0] r, c, x1, x2, x3, x4, a64, m64, nxt;
        logic        ok;
        res = '0;
        if (m < 2) return res;
        a64 = 64'(a);
        m64 = 64'(m);
        x1 = 64'(observed[REG_FIRST]);
        x2 = 64'(observed[REG_SECOND]);
        x3 = 64'(observed[REG_THIRD]);
        x4 = 64'(observed[REG_FOURTH]);
        r = (a64 * x1) % m64;
        c = (x2 >= r) ? x2 - r : x2 + m64 - r;
        ok = (step_mod(a64, x1, c, m64) == x2) && (step_mod(a64, x2, c, m64) == x3) &&
             (step_mod(a64, x3, c, m64) == x4);
        nxt = step_mod(a64, x4, c, m64);
        res.match = ok;
        res.increment = c[VALUE_BITS-1:0];
        res.predicted_next = nxt[VALUE_BITS-1:0];
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        return $urandom_range(0, 2);
    endfunction

    // result side
    always @(posedge aclk) begin
        lcg_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[32:17]};
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp match %b inc %h next %h, got %b %h %h",
                                 want.match, want.increment, want.predicted_next,
                                 got.match, got.increment, got.predicted_next);
                end else if (got.match) begin
                    match_count <= match_count + 1;
                end
            end
        end
    end

    int rx_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else if (hold_off_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (!rx_random_stall) begin
            m_axis_tready <= 1'b1;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap = gap_len();
        end
    end

    task automatic send_candidate(value_t a, value_t m, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : gap_len();
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {m, a};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_results.push_back(check_candidate(a, m));
        candidate_count++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        int waited;
        stop_sending();
        waited = 0;
        while (expected_results.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, value_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        observed[idx] = val;
    endtask

    // x1 as given, x2..x4 generated by a real generator so matches occur
    task automatic load_sequence(value_t a, value_t c, value_t m, value_t x1);
        logic [63:0] x;
        x = 64'(x1);
        write_reg(REG_FIRST, x[VALUE_BITS-1:0]);
        x = step_mod(64'(a), x, 64'(c), 64'(m));
        write_reg(REG_SECOND, x[VALUE_BITS-1:0]);
        x = step_mod(64'(a), x, 64'(c), 64'(m));
        write_reg(REG_THIRD, x[VALUE_BITS-1:0]);
        x = step_mod(64'(a), x, 64'(c), 64'(m));
        write_reg(REG_FOURTH, x[VALUE_BITS-1:0]);
    endtask

    task automatic test_directed();
        value_t m;
        send_candidate(16'h0000, 16'h0000);
        send_candidate(16'hffff, 16'h0001);
        send_candidate(16'h1234, 16'h0002);
        send_candidate(16'hffff, 16'hffff);
        drain();
        write_reg(REG_FIRST, 16'hffff);
        write_reg(REG_SECOND, 16'hffff);
        write_reg(REG_THIRD, 16'hffff);
        write_reg(REG_FOURTH, 16'hffff);
        send_candidate(16'hffff, 16'hffff);
        send_candidate(16'h0001, 16'hfffe);
        send_candidate(16'h0000, 16'h0001);
        send_candidate(16'h8000, 16'h8001);
        drain();
        // true generator, one exact hit and near misses
        load_sequence(16'd75, 16'd74, 16'd65521, 16'd12345);
        send_candidate(16'd75, 16'd65521);
        send_candidate(16'd76, 16'd65521);
        send_candidate(16'd75, 16'd65520);
        send_candidate(16'd75, 16'd100);
        drain();
        load_sequence(16'hfffe, 16'hfffd, 16'hffff, 16'h0000);
        send_candidate(16'hfffe, 16'hffff);
        send_candidate(16'hfffe, 16'h0002);
        m = 16'hffff;
        send_candidate(16'h5555, m);
        send_candidate(16'haaaa, m);
        drain();
    endtask

    task automatic test_random(int n);
        value_t a, c, m, x1;
        for (int k = 0; k < n / 50; k++) begin
            m = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(2, 64));
            if (m < 2) m = 2;
            a = 16'($urandom % 32'(m));
            c = 16'($urandom % 32'(m));
            x1 = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom % 32'(m));
            load_sequence(a, c, m, x1);
            for (int i = 0; i < 50; i++) begin
                case ($urandom_range(0, 4))
                    0: send_candidate(16'($urandom), 16'($urandom));
                    1: send_candidate(16'($urandom), 16'($urandom_range(0, 3)));
                    2: send_candidate(a, m);
                    default:
                        send_candidate(16'($urandom % 32'(m)),
                                       16'(m + $urandom_range(0, 2) - 1));
                endcase
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        rx_random_stall = 1'b0;
        hold_off_cycles <= 3 * LATENCY;
        for (int i = 0; i < 3 * LATENCY; i++)
            send_candidate(16'($urandom), 16'($urandom), 1);
        drain();
        rx_random_stall = 1'b1;
    endtask

    initial begin
        mismatch_count = 0;
        result_count = 0;
        candidate_count = 0;
        match_count = 0;
        hold_off_cycles = 0;
        rx_random_stall = 1'b1;
        foreach (observed[i]) observed[i] = '0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(400);
        drain();
        $display("%0d candidates checked, %0d results, %0d matches, %0d mismatches",
                 candidate_count, result_count, match_count, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[lcg_candidate_checker_top.f]
design/lcgcc_pkg.sv
design/lcgcc_mul_stage.sv
design/lcgcc_mod_cell.sv
design/lcgcc_check.sv
design/lcg_candidate_checker_top.sv
verif/tb_top.sv
